### rtl/core/sli_pkg.sv
// Shared types and codes for the sorted list insert/remove block.
package sli_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic              func;
    logic signed [31:0] value;
  } sli_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         entry_count;
    logic signed [31:0] smallest_value;
  } sli_out_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic               ins_en;
    logic               rem_en;
    logic signed [31:0] key;
  } sli_ctrl_t;

  // What a cell shows its neighbors and the top level
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic               ge;     // valid and value >= key
    logic               open;   // insert lands here or further left
  } sli_link_t;

endpackage

### rtl/core/sorted_list_insert_remove.sv
// Top level of the sorted list: cell chain, found detection and result register.
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of cells,
// one value per cell. Every cell compares its value with the incoming key at once,
// so a new transfer can be taken every cycle that the result side keeps up; the
// result is registered and appears in the cycle after the input transfer. The
// critical path is one 32-bit compare per cell plus the OR across all cells that
// decides whether a remove found its value. Inserts go ahead of equal stored
// values; an insert into a full list is dropped (status full), a remove of an
// absent value reports not found, and a remove from an empty list reports empty.
// Each result also carries the entry count and the head value.
module sorted_list_insert_remove import sli_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sli_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sli_out_t out_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  sli_ctrl_t              ctrl;
  sli_link_t              links [CAPACITY];
  logic [CAPACITY-1:0]    hit_vec;
  logic [CAPACITY-1:0]    valid_vec;
  logic                   in_xfer, is_ins, is_rem, full, empty, found;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW+4:0]          count_ext;
  logic                   out_valid_r;
  logic [1:0]             status_r, status_nxt;
  logic signed [31:0]     removed_r, removed_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign is_ins   = in_data.func == FUNC_INSERT;
  assign is_rem   = in_data.func == FUNC_REMOVE;
  assign full     = links[CAPACITY-1].valid;
  assign empty    = !links[0].valid;
  assign found    = |hit_vec;

  assign ctrl.key    = in_data.value;
  assign ctrl.ins_en = in_xfer && is_ins && !full;
  assign ctrl.rem_en = in_xfer && is_rem && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int unsigned LI = (i == 0) ? 0 : i - 1;
    localparam int unsigned RI = (i == CAPACITY - 1) ? i : i + 1;
    sli_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_link  (links[LI]),
      .has_left   (i != 0),
      .right_link (links[RI]),
      .has_right  (i != CAPACITY - 1),
      .link       (links[i]),
      .hit        (hit_vec[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  always_comb begin
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    removed_nxt = '0;
    if (is_ins) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else if (empty) begin
      status_nxt = ST_EMPTY;
    end else if (!found) begin
      status_nxt = ST_NOT_FOUND;
    end else begin
      count_nxt   = count_r - CW'(1);
      removed_nxt = in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r <= count_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
    end
  end

  // store only changes on an input transfer, which never leaves a result pending
  assign count_ext               = (CW + 5)'(count_r);
  assign out_valid               = out_valid_r;
  assign out_data.status         = status_r;
  assign out_data.removed_value  = removed_r;
  assign out_data.entry_count    = count_ext[4:0];
  assign out_data.smallest_value = links[0].valid ? links[0].value : 32'sd0;

  a_packed_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec & (valid_vec + CAPACITY'(1))) == '0) &&
    ($countones(valid_vec) == count_r))
    else $error("valid bits not packed or count mismatch");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one removal candidate");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins_en |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the list");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rem_en |=> count_r == $past(count_r) - CW'(1))
    else $error("remove did not shrink the list");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid)
    else $error("no result after input transfer");

endmodule

### rtl/core/sli_cell.sv
// One slot of the sorted chain: compare against the key and shift left or right.
module sli_cell import sli_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sli_ctrl_t ctrl,
  input  sli_link_t left_link,
  input  logic      has_left,
  input  sli_link_t right_link,
  input  logic      has_right,
  output sli_link_t link,
  output logic      hit
);

  logic               valid_r, valid_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic               ge, open, left_open, left_ge;

  assign ge        = valid_r && (value_r >= ctrl.key);
  assign open      = !valid_r || ge;
  assign left_open = has_left && left_link.open;
  assign left_ge   = has_left && left_link.ge;

  // first stored entry not below the key, and it matches
  assign hit = ge && !left_ge && (value_r == ctrl.key);

  assign link.valid = valid_r;
  assign link.value = value_r;
  assign link.ge    = ge;
  assign link.open  = open;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.ins_en && open) begin
      if (left_open) begin
        value_nxt = left_link.value;
        valid_nxt = left_link.valid;
      end else begin
        value_nxt = ctrl.key;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.rem_en && ge) begin
      value_nxt = right_link.value;
      valid_nxt = has_right && right_link.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

### bench/sorted_list_insert_remove_test.sv
// Self-checking bench for the sorted list block: directed table, then random traffic.
module sorted_list_insert_remove_test;
  import sli_pkg::*;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam int RANDOM_ITEMS = 400;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct {
    sli_in_t  item;
    bit       typed;   // use the typed-in result instead of the list model
    sli_out_t want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sli_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sli_out_t out_data;

  sorted_list_insert_remove dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the stored list, ascending, plus the results still owed by the block
  logic signed [31:0] sorted_store[$];
  sli_out_t pending_results[$];
  bit no_idle = 1'b0;
  int mismatches = 0;
  int results_seen = 0;
  int status_seen[4];
  int peak_fill = 0;

  always @(negedge clk) out_ready <= no_idle || ($urandom_range(0, 99) >= 7);

  function automatic sli_out_t apply_op(input sli_in_t item);
    sli_out_t r;
    int pos;
    r = '0;
    pos = sorted_store.size();
    if (item.func == FUNC_INSERT) begin
      if (sorted_store.size() >= CAPACITY_DEF) begin
        r.status = ST_FULL;
      end else begin
        for (int i = 0; i < sorted_store.size(); i++)
          if (pos == sorted_store.size() && sorted_store[i] >= item.value) pos = i;
        sorted_store.insert(pos, item.value);
        r.status = ST_OK;
      end
    end else if (sorted_store.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      for (int i = 0; i < sorted_store.size(); i++)
        if (pos == sorted_store.size() && sorted_store[i] == item.value) pos = i;
      if (pos == sorted_store.size()) begin
        r.status = ST_NOT_FOUND;
      end else begin
        sorted_store.delete(pos);
        r.status = ST_OK;
        r.removed_value = item.value;
      end
    end
    r.entry_count = 5'(sorted_store.size());
    r.smallest_value = (sorted_store.size() > 0) ? sorted_store[0] : 32'sd0;
    status_seen[r.status]++;
    if (sorted_store.size() > peak_fill) peak_fill = sorted_store.size();
    return r;
  endfunction

  function automatic dir_row_t mk_row(input logic f, input logic signed [31:0] v,
                                      input bit typed = 1'b0, input logic [1:0] st = ST_OK,
                                      input logic signed [31:0] rem = 0,
                                      input logic [4:0] cnt = 0,
                                      input logic signed [31:0] head = 0);
    dir_row_t row;
    row.item.func = f;
    row.item.value = v;
    row.typed = typed;
    row.want.status = st;
    row.want.removed_value = rem;
    row.want.entry_count = cnt;
    row.want.smallest_value = head;
    return row;
  endfunction

  function automatic logic signed [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return $urandom_range(0, 16) - 8;
    if (roll == 4) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic sli_in_t next_random(input int insert_pct);
    sli_in_t item;
    item.func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
    item.value = pick_value();
    // Most removes name a value that is actually stored
    if (item.func == FUNC_REMOVE && sorted_store.size() > 0 && $urandom_range(0, 99) < 65)
      item.value = sorted_store[$urandom_range(0, sorted_store.size() - 1)];
    return item;
  endfunction

  // Present one item; on transfer, record what the block owes for it
  task automatic send_item(input sli_in_t item, input bit typed, input sli_out_t want,
                           input bit drain);
    sli_out_t model_out;
    @(negedge clk);
    if (drain || (!no_idle && $urandom_range(0, 99) < 7)) begin
      in_valid <= 1'b0;
      do @(negedge clk);
      while (drain ? pending_results.size() != 0 : $urandom_range(0, 99) < 7);
    end
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    model_out = apply_op(item);
    pending_results.push_back(typed ? want : model_out);
  endtask

  task automatic report_mismatch(input string field, input longint want, input longint got);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES)
      $display("mismatch on result %0d, %s: expected %0d, got %0d",
               results_seen, field, want, got);
  endtask

  always @(posedge clk) begin
    sli_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", want.status, out_data.status);
        if (out_data.removed_value !== want.removed_value)
          report_mismatch("removed_value", want.removed_value, out_data.removed_value);
        if (out_data.entry_count !== want.entry_count)
          report_mismatch("entry_count", want.entry_count, out_data.entry_count);
        if (out_data.smallest_value !== want.smallest_value)
          report_mismatch("smallest_value", want.smallest_value, out_data.smallest_value);
      end
      results_seen++;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    sli_out_t none;
    none = '0;

    dir_rows.push_back(mk_row(FUNC_REMOVE, 32'sd0, 1, ST_EMPTY, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_INSERT, VAL_MAX, 1, ST_OK, 0, 1, VAL_MAX));
    dir_rows.push_back(mk_row(FUNC_INSERT, VAL_MIN, 1, ST_OK, 0, 2, VAL_MIN));
    dir_rows.push_back(mk_row(FUNC_INSERT, 32'sd0));
    dir_rows.push_back(mk_row(FUNC_INSERT, 32'sd0));   // equal value goes ahead
    dir_rows.push_back(mk_row(FUNC_REMOVE, 32'sd5, 1, ST_NOT_FOUND, 0, 4, VAL_MIN));
    dir_rows.push_back(mk_row(FUNC_REMOVE, VAL_MIN, 1, ST_OK, VAL_MIN, 3, 0));
    // fill up to capacity
    dir_rows.push_back(mk_row(FUNC_INSERT, -32'sd1));
    dir_rows.push_back(mk_row(FUNC_INSERT, 32'sd1));
    dir_rows.push_back(mk_row(FUNC_INSERT, 32'sh5555_5555));
    dir_rows.push_back(mk_row(FUNC_INSERT, 32'shAAAA_AAAA));
    dir_rows.push_back(mk_row(FUNC_INSERT, VAL_MIN));
    dir_rows.push_back(mk_row(FUNC_INSERT, VAL_MAX));
    dir_rows.push_back(mk_row(FUNC_INSERT, 32'sd0));
    dir_rows.push_back(mk_row(FUNC_INSERT, -32'sd2));
    dir_rows.push_back(mk_row(FUNC_INSERT, 32'sd2));
    dir_rows.push_back(mk_row(FUNC_INSERT, 32'sd100));
    dir_rows.push_back(mk_row(FUNC_INSERT, -32'sd100));
    dir_rows.push_back(mk_row(FUNC_INSERT, 32'sd7));
    dir_rows.push_back(mk_row(FUNC_INSERT, 32'sd7));
    dir_rows.push_back(mk_row(FUNC_INSERT, 32'sd3, 1, ST_FULL, 0, 16, VAL_MIN));
    dir_rows.push_back(mk_row(FUNC_REMOVE, VAL_MIN));
    dir_rows.push_back(mk_row(FUNC_REMOVE, VAL_MAX));
    dir_rows.push_back(mk_row(FUNC_REMOVE, 32'sd0));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want, 1'b0);

    // Random phases lean toward insert or remove so the list swings full and empty
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      no_idle = (k >= 250 && k < 350);
      case ((k / 40) % 3)
        0: send_item(next_random(85), 1'b0, none, k == 200);
        1: send_item(next_random(50), 1'b0, none, k == 200);
        default: send_item(next_random(15), 1'b0, none, k == 200);
      endcase
    end
    @(negedge clk);
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) report_mismatch("results still pending", 0,
                                                     pending_results.size());

    $display("%0d results checked over %0d items; peak fill %0d of %0d", results_seen,
             dir_rows.size() + RANDOM_ITEMS, peak_fill, CAPACITY_DEF);
    $display("status counts: ok %0d, full %0d, not found %0d, empty %0d; mismatches %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
             status_seen[ST_EMPTY], mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout: %0d results still pending", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
